### hdl/plt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package plt_pkg;

   // Table depth used when the top level is not given another.
   localparam int TABLE_DEPTH_DEF = 16;

   // At most this many results are reported for one request.
   localparam int MAX_RESULTS = 16;
   localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

   // Field widths of requests and results.
   localparam int CMD_W  = 2;
   localparam int MSG_W  = 8;
   localparam int ADDR_W = 32;
   localparam int PORT_W = 16;
   localparam int KIND_W = 3;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_MESSAGE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_TICK    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd2;

   // Message type codes.
   localparam logic [MSG_W-1:0] MSG_JOIN      = 8'd1;
   localparam logic [MSG_W-1:0] MSG_HEARTBEAT = 8'd2;

   // Register file layout.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-3:0] CSR_WORKING_ENABLE = 1'b0;

   // Result kinds.
   typedef enum logic [KIND_W-1:0] {
      EV_NONE    = 3'd0,
      EV_ECHO    = 3'd1,
      EV_ADDED   = 3'd2,
      EV_REMOVED = 3'd3,
      EV_FULL    = 3'd4
   } event_kind_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic           load;
      logic           clear_count;
      logic           idx_reset;
      logic           step;
      logic           mark_active;
      logic           keep;
      logic           append;
      logic           commit_count;
      logic           stage;
      event_kind_type stage_kind;
      logic           flush;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_clear;
      logic is_tick;
      logic is_join;
      logic is_heartbeat;
      logic scan_done;
      logic match;
      logic rd_active;
      logic table_full;
      logic pend_valid;
      logic out_busy;
      logic cap_reached;
   } ctrl_status_type;

endpackage

`default_nettype wire

### hdl/peer_liveness_table.sv
`timescale 1ns / 1ps
`default_nettype none

// Peer liveness table: keeps up to TABLE_DEPTH peers (address, port, active bit)
// in join order. A join marks a known peer active, or appends a new one if there
// is room; it is echoed, and for an unknown peer an added report (with port+1)
// or a full-table report follows; a heartbeat marks a known peer active; a tick
// removes every inactive peer, reports up to MAX_RESULTS of them, compacts the
// table and clears the survivors' active bits; a clear empties the table even
// while disabled. Requests are taken one at a time. A join, heartbeat or tick
// walks the table through a memory with a registered read; a join or heartbeat
// that hits an entry stops there. A stall on the result side holds up a request.
// The block comes out of reset ready, with an empty table and disabled.
module peer_liveness_table import plt_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Request channel.
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [47:0]           req_tdata,   // peer_addr[31:0], peer_port[47:32]
   input  wire logic [9:0]            req_tuser,   // command[1:0], message_type[9:2]
   // Result channel.
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [47:0]                rsp_tdata,   // event_addr[31:0], event_port[47:32]
   output logic [2:0]                 rsp_tuser,   // event_kind[2:0]
   output logic                       rsp_tlast,
   // Register port.
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   logic            working_enable;
   ctrl_cmd_type    cmd;
   ctrl_status_type status;
   logic [ADDR_W-1:0] event_addr;
   logic [PORT_W-1:0] event_port;

   plt_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .working_enable (working_enable)
   );

   plt_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_tvalid),
      .req_ready      (req_tready),
      .working_enable (working_enable),
      .status         (status),
      .cmd            (cmd)
   );

   plt_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_command      (req_tuser[CMD_W-1:0]),
      .req_message_type (req_tuser[CMD_W+MSG_W-1:CMD_W]),
      .req_peer_addr    (req_tdata[ADDR_W-1:0]),
      .req_peer_port    (req_tdata[ADDR_W+PORT_W-1:ADDR_W]),
      .rsp_ready        (rsp_tready),
      .rsp_valid        (rsp_tvalid),
      .rsp_event_kind   (rsp_tuser),
      .rsp_event_addr   (event_addr),
      .rsp_event_port   (event_port),
      .rsp_last_result  (rsp_tlast)
   );

   assign rsp_tdata = {event_port, event_addr};

endmodule

`default_nettype wire

### hdl/plt_csr.sv
`timescale 1ns / 1ps
`default_nettype none

module plt_csr import plt_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready,
   output logic                       working_enable
);

   logic                  enable_ff;
   logic                  enable_in;
   logic [CSR_ADDR_W-3:0] reg_index;
   logic                  write_hit;

   // Registers sit on word boundaries.
   assign reg_index  = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_pready = 1'b1;
   assign write_hit  = csr_psel & csr_penable & csr_pwrite & csr_pready
                       & (reg_index == CSR_WORKING_ENABLE);

   // Enable register update.
   always_comb begin
      enable_in = enable_ff;
      if (write_hit) begin
         enable_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
      end else begin
         enable_ff <= enable_in;
      end
   end

   // Read back the addressed register.
   always_comb begin
      csr_prdata = '0;
      if (reg_index == CSR_WORKING_ENABLE) begin
         csr_prdata[0] = enable_ff;
      end
   end

   assign working_enable = enable_ff;

endmodule

`default_nettype wire

### hdl/plt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module plt_ctrl import plt_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire logic            working_enable,
   input  wire ctrl_status_type status,
   output ctrl_cmd_type         cmd
);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_DECODE = 7'b0000010,
      ST_CHECK  = 7'b0000100,
      ST_EVAL   = 7'b0001000,
      ST_ECHO   = 7'b0010000,
      ST_JOIN2  = 7'b0100000,
      ST_FLUSH  = 7'b1000000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      hit_ff;
   logic      hit_in;

   // Sequencer for search, compaction and result emission.
   always_comb begin
      state_in  = state_ff;
      hit_in    = hit_ff;
      cmd       = '0;
      cmd.stage_kind = EV_NONE;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               hit_in   = 1'b0;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (status.is_clear) begin
               cmd.clear_count = 1'b1;
               state_in        = ST_IDLE;
            end else if (!working_enable) begin
               state_in = ST_IDLE;
            end else if (status.is_tick || status.is_join || status.is_heartbeat) begin
               cmd.idx_reset = 1'b1;
               state_in      = ST_CHECK;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_CHECK: begin
            // The table entry at the scan index is read during this cycle.
            if (status.scan_done) begin
               if (status.is_tick) begin
                  cmd.commit_count = 1'b1;
                  state_in = status.pend_valid ? ST_FLUSH : ST_IDLE;
               end else if (status.is_join) begin
                  state_in = ST_ECHO;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (status.is_tick) begin
               if (status.rd_active) begin
                  cmd.keep = 1'b1;
                  cmd.step = 1'b1;
                  state_in = ST_CHECK;
               end else if (status.cap_reached) begin
                  cmd.step = 1'b1;
                  state_in = ST_CHECK;
               end else if (!status.pend_valid || !status.out_busy) begin
                  cmd.stage      = 1'b1;
                  cmd.stage_kind = EV_REMOVED;
                  cmd.step       = 1'b1;
                  state_in       = ST_CHECK;
               end
            end else if (status.match) begin
               cmd.mark_active = 1'b1;
               if (status.is_join) begin
                  hit_in   = 1'b1;
                  state_in = ST_ECHO;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               cmd.step = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_ECHO: begin
            // Nothing is pending yet, so the echo can always be staged.
            cmd.stage      = 1'b1;
            cmd.stage_kind = EV_ECHO;
            state_in       = hit_ff ? ST_FLUSH : ST_JOIN2;
         end
         ST_JOIN2: begin
            if (!status.out_busy) begin
               cmd.stage = 1'b1;
               if (status.table_full) begin
                  cmd.stage_kind = EV_FULL;
               end else begin
                  cmd.stage_kind = EV_ADDED;
                  cmd.append     = 1'b1;
               end
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (!status.out_busy) begin
               cmd.flush = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         hit_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         hit_ff   <= hit_in;
      end
   end

endmodule

`default_nettype wire

### hdl/plt_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module plt_datapath import plt_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ctrl_cmd_type      cmd,
   output ctrl_status_type        status,
   input  wire logic [CMD_W-1:0]  req_command,
   input  wire logic [MSG_W-1:0]  req_message_type,
   input  wire logic [ADDR_W-1:0] req_peer_addr,
   input  wire logic [PORT_W-1:0] req_peer_port,
   input  wire logic              rsp_ready,
   output logic                   rsp_valid,
   output logic [KIND_W-1:0]      rsp_event_kind,
   output logic [ADDR_W-1:0]      rsp_event_addr,
   output logic [PORT_W-1:0]      rsp_event_port,
   output logic                   rsp_last_result
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   // Peer table memories.
   logic [ADDR_W-1:0] tbl_addr_mem [TABLE_DEPTH];
   logic [PORT_W-1:0] tbl_port_mem [TABLE_DEPTH];
   logic              tbl_act_mem  [TABLE_DEPTH];

   // Current request.
   logic [CMD_W-1:0]  item_cmd_ff;
   logic [MSG_W-1:0]  item_type_ff;
   logic [ADDR_W-1:0] item_addr_ff;
   logic [PORT_W-1:0] item_port_ff;

   // Registered table read data.
   logic [ADDR_W-1:0] rd_addr_ff;
   logic [PORT_W-1:0] rd_port_ff;
   logic              rd_active_ff;

   // Scan and table counters.
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     i_ff, i_in;
   logic [CNT_W-1:0]     w_ff, w_in;
   logic [RES_CNT_W-1:0] n_ff, n_in;

   // Pending result and output register.
   logic              pend_valid_ff, pend_valid_in;
   event_kind_type    pend_kind_ff;
   logic [ADDR_W-1:0] pend_addr_ff;
   logic [PORT_W-1:0] pend_port_ff;
   logic              out_valid_ff, out_valid_in;
   event_kind_type    out_kind_ff;
   logic [ADDR_W-1:0] out_addr_ff;
   logic [PORT_W-1:0] out_port_ff;
   logic              out_last_ff;
   logic              out_load;

   // Write port selection.
   logic              tbl_we;
   logic [IDX_W-1:0]  tbl_wa;
   logic [ADDR_W-1:0] tbl_wd_addr;
   logic [PORT_W-1:0] tbl_wd_port;
   logic              act_we;
   logic [IDX_W-1:0]  act_wa;
   logic              act_wd;

   // New result data.
   logic [ADDR_W-1:0] stage_addr;
   logic [PORT_W-1:0] stage_port;

   // Table write port: compaction writes at the write index, a join appends at the end.
   always_comb begin
      tbl_we      = cmd.keep | cmd.append;
      tbl_wa      = cmd.append ? count_ff[IDX_W-1:0] : w_ff[IDX_W-1:0];
      tbl_wd_addr = cmd.append ? item_addr_ff : rd_addr_ff;
      tbl_wd_port = cmd.append ? item_port_ff : rd_port_ff;
      act_we      = cmd.keep | cmd.append | cmd.mark_active;
      act_wd      = ~cmd.keep;
      if (cmd.mark_active) begin
         act_wa = i_ff[IDX_W-1:0];
      end else if (cmd.append) begin
         act_wa = count_ff[IDX_W-1:0];
      end else begin
         act_wa = w_ff[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_addr_mem[tbl_wa] <= tbl_wd_addr;
         tbl_port_mem[tbl_wa] <= tbl_wd_port;
      end
      if (act_we) begin
         tbl_act_mem[act_wa] <= act_wd;
      end
      rd_addr_ff   <= tbl_addr_mem[i_ff[IDX_W-1:0]];
      rd_port_ff   <= tbl_port_mem[i_ff[IDX_W-1:0]];
      rd_active_ff <= tbl_act_mem[i_ff[IDX_W-1:0]];
   end

   // Request capture.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_cmd_ff  <= req_command;
         item_type_ff <= req_message_type;
         item_addr_ff <= req_peer_addr;
         item_port_ff <= req_peer_port;
      end
   end

   // Counter updates.
   always_comb begin
      count_in = count_ff;
      if (cmd.clear_count) begin
         count_in = '0;
      end else if (cmd.append) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.commit_count) begin
         count_in = w_ff;
      end
      i_in = i_ff;
      w_in = w_ff;
      n_in = n_ff;
      if (cmd.idx_reset) begin
         i_in = '0;
         w_in = '0;
         n_in = '0;
      end else begin
         if (cmd.step) begin
            i_in = i_ff + CNT_W'(1);
         end
         if (cmd.keep) begin
            w_in = w_ff + CNT_W'(1);
         end
         if (cmd.stage) begin
            n_in = n_ff + RES_CNT_W'(1);
         end
      end
   end

   // Data of a newly staged result.
   always_comb begin
      unique case (cmd.stage_kind)
         EV_ADDED: begin
            stage_addr = item_addr_ff;
            stage_port = item_port_ff + PORT_W'(1);
         end
         EV_REMOVED: begin
            stage_addr = rd_addr_ff;
            stage_port = rd_port_ff + PORT_W'(1);
         end
         default: begin
            stage_addr = item_addr_ff;
            stage_port = item_port_ff;
         end
      endcase
   end

   // A staged result waits until the next one shows whether it was the last.
   always_comb begin
      out_load      = cmd.flush | (cmd.stage & pend_valid_ff);
      pend_valid_in = pend_valid_ff;
      if (cmd.stage) begin
         pend_valid_in = 1'b1;
      end else if (cmd.flush) begin
         pend_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         i_ff          <= '0;
         w_ff          <= '0;
         n_ff          <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         i_ff          <= i_in;
         w_ff          <= w_in;
         n_ff          <= n_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.stage) begin
         pend_kind_ff <= cmd.stage_kind;
         pend_addr_ff <= stage_addr;
         pend_port_ff <= stage_port;
      end
      if (out_load) begin
         out_kind_ff <= pend_kind_ff;
         out_addr_ff <= pend_addr_ff;
         out_port_ff <= pend_port_ff;
         out_last_ff <= cmd.flush;
      end
   end

   // Status toward the controller.
   always_comb begin
      status.is_clear     = (item_cmd_ff == CMD_CLEAR);
      status.is_tick      = (item_cmd_ff == CMD_TICK);
      status.is_join      = (item_cmd_ff == CMD_MESSAGE) && (item_type_ff == MSG_JOIN);
      status.is_heartbeat = (item_cmd_ff == CMD_MESSAGE) && (item_type_ff == MSG_HEARTBEAT);
      status.scan_done    = (i_ff == count_ff);
      status.match        = (rd_addr_ff == item_addr_ff) && (rd_port_ff == item_port_ff);
      status.rd_active    = rd_active_ff;
      status.table_full   = (count_ff == CNT_W'(TABLE_DEPTH));
      status.pend_valid   = pend_valid_ff;
      status.out_busy     = out_valid_ff & ~rsp_ready;
      status.cap_reached  = (n_ff == RES_CNT_W'(MAX_RESULTS));
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_event_kind  = out_kind_ff;
   assign rsp_event_addr  = out_addr_ff;
   assign rsp_event_port  = out_port_ff;
   assign rsp_last_result = out_last_ff;

   // The table never holds more peers than it has room for.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("peer count exceeds table depth");

   // Compaction never writes ahead of the read index.
   a_write_behind_read: assert property (@(posedge clock) disable iff (reset)
      w_ff <= i_ff)
      else $error("compaction write index passed read index");

   // A flush always has a pending result to move.
   a_flush_pending: assert property (@(posedge clock) disable iff (reset)
      cmd.flush |-> pend_valid_ff)
      else $error("flush without pending result");

   // A held result is never overwritten.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_load |-> !(out_valid_ff && !rsp_ready))
      else $error("output register overwritten while stalled");

   // An append grows the table by one peer.
   a_append_room: assert property (@(posedge clock) disable iff (reset)
      cmd.append |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("append did not grow the table");

endmodule

`default_nettype wire
